// ===== src/nearest_palette_color_search_defines.svh =====
// Assertion macros for the nearest palette color search checker.
// No dependencies; included by the checker file.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// same-cycle implication, reset masked
`define NPCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npcs assertion failed");

// next-cycle implication, reset masked
`define NPCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npcs assertion failed");

`endif

// ===== src/npcs_pkg.sv =====
// Shared types, constants and helpers for the nearest palette color search.
// No dependencies.
package npcs_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int DIST_W              = 18;

  localparam logic       KIND_LOAD    = 1'b0;
  localparam logic       KIND_QUERY   = 1'b1;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  typedef struct packed {
    logic        kind;
    logic [7:0]  entry_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] color_code;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       packed_color;
    logic [7:0]        nearest_index;
    logic [DIST_W-1:0] distance;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // (c << 3) + 4
  function automatic logic [7:0] widen5(input logic [4:0] c);
    return {c, 3'b100};
  endfunction

  function automatic logic [15:0] sqdiff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

endpackage

// ===== src/nearest_palette_color_search.sv =====
// Nearest palette color search: palette memory, scan sequencer, distance pipe.
// Depends on npcs_pkg.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------
//  input    | start / busy       | item   (in_item_t)
//  result   | done (1-cycle)     | result (out_item_t)
//
// A load's result shows the next cycle and busy stays low.
// A query makes one palette memory read per entry through a three-stage
// read/square/compare pipe; busy is high until its result shows.
// Reset clears sequencer and pipe valids; palette contents stay undefined.
// The receiver cannot stall: each result is a one-cycle transfer.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  npcs_pkg::in_item_t  item,
  output logic                done,
  output npcs_pkg::out_item_t result
);
  import npcs_pkg::*;

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [8:0]       N_ENTRIES = 9'(PALETTE_ENTRIES);
  localparam logic [7:0]       CLEAR_IDX = 8'(PALETTE_ENTRIES - 1);

  state_t state, state_next;
  logic   scan_en;
  logic   accept;

  logic [23:0] mem [PALETTE_ENTRIES];

  logic [7:0] qr, qg, qb;
  logic [IDX_W-1:0] rd_addr;

  logic             v1, l1;
  logic [IDX_W-1:0] i1;
  logic [23:0]      rd_data;

  logic             v2, l2;
  logic [IDX_W-1:0] i2;
  logic [15:0]      sq_r, sq_g, sq_b;

  logic [DIST_W-1:0] best_dist, best_dist_next, cand;
  logic [IDX_W-1:0]  best_idx, best_idx_next;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && item.kind == KIND_QUERY) state_next = ST_SCAN;
      ST_SCAN:  if (rd_addr == LAST_IDX) state_next = ST_FLUSH;
      ST_FLUSH: if (v2 && l2) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    scan_en = 1'b0;
    case (state)
      ST_IDLE:  busy = 1'b0;
      ST_SCAN:  scan_en = 1'b1;
      ST_FLUSH: ;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // palette memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_LOAD && {1'b0, item.entry_index} < N_ENTRIES) begin
      mem[item.entry_index[IDX_W-1:0]] <= {item.blue, item.green, item.red};
    end
    if (scan_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_QUERY) begin
      qr <= widen5(item.color_code[4:0]);
      qg <= widen5(item.color_code[9:5]);
      qb <= widen5(item.color_code[14:10]);
    end
    if (state == ST_IDLE)  rd_addr <= '0;
    else if (scan_en)      rd_addr <= rd_addr + IDX_W'(1);
    i1 <= rd_addr;
    l1 <= (rd_addr == LAST_IDX);
    i2 <= i1;
    l2 <= l1;
    sq_r <= sqdiff(qr, rd_data[7:0]);
    sq_g <= sqdiff(qg, rd_data[15:8]);
    sq_b <= sqdiff(qb, rd_data[23:16]);
    if (v2) begin
      best_dist <= best_dist_next;
      best_idx  <= best_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= scan_en;
      v2 <= v1;
    end
  end

  // compare stage; first entry always seeds the running best
  always_comb begin
    cand           = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
    best_dist_next = best_dist;
    best_idx_next  = best_idx;
    if (i2 == '0 || cand < best_dist) begin
      best_dist_next = cand;
      best_idx_next  = i2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && item.kind == KIND_LOAD) || (v2 && l2);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.kind == KIND_LOAD) begin
      result.packed_color  <= {(item.entry_index == CLEAR_IDX) ? ALPHA_CLEAR : ALPHA_OPAQUE,
                               item.blue, item.green, item.red};
      result.nearest_index <= '0;
      result.distance      <= '0;
    end else if (v2 && l2) begin
      result.packed_color  <= '0;
      result.nearest_index <= 8'(best_idx_next);
      result.distance      <= best_dist_next;
    end
  end

endmodule

// ===== src/npcs_checker.sv =====
// Port-level checker for the nearest palette color search, with its bind.
// Depends on npcs_pkg and nearest_palette_color_search_defines.svh.
`include "nearest_palette_color_search_defines.svh"

module npcs_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input npcs_pkg::in_item_t  item,
  input logic                done,
  input npcs_pkg::out_item_t result
);
  import npcs_pkg::*;

  // load transfer returns its packed entry on the very next cycle
  `NPCS_ASSERT_NEXT(a_load_result, start && !busy && item.kind == KIND_LOAD, done && result.packed_color[23:0] == {$past(item.blue), $past(item.green), $past(item.red)})
  // query holds the block busy
  `NPCS_ASSERT_NEXT(a_query_busy, start && !busy && item.kind == KIND_QUERY, busy)
  // query result never appears the cycle after the transfer
  `NPCS_ASSERT_NEXT(a_query_latency, start && !busy && item.kind == KIND_QUERY, !done)
  // a result carries either load fields or query fields
  `NPCS_ASSERT_NOW(a_result_kind, done, result.packed_color == 32'd0 || (result.nearest_index == 8'd0 && result.distance == '0))

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);
